>>> hw/rtl/ctsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_pkg
// Shared types, fixed-point constants and small tables for the cube face to
// equirectangular sample coordinate pipeline.
// ----------------------------------------------------------------------------
package ctsc_pkg;

   // Q2.14 fixed point: 16384 is one, and for angles one half-turn.
   localparam int Q14_ONE  = 16384;
   localparam int Q14_HALF = 8192;
   localparam int Q14_FRAC = 14;

   // Field widths of the channels.
   localparam int FACE_W  = 3;
   localparam int PIX_W   = 11;
   localparam int COORD_W = 13;
   localparam int COORD_Q_W = 16;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;
   localparam logic [CSR_IDX_W-1:0] CSR_FACE_SIZE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_X_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_Y_MAX = 2'd2;

   // Divider: the face-relative quotient is only needed up to the point where
   // both derived coordinates saturate, which is three in Q14 (num/fs of 3/2).
   localparam int QUO_W   = 16;
   localparam int QUO_SAT = 49152;
   localparam int DIV_BITS_PER_STAGE = 2;

   // CORDIC vectoring.
   localparam int CRD_STEPS      = 14;
   localparam int CRD_PER_STAGE  = 2;
   localparam int CRD_W          = 20;
   localparam int CRD_IN_W       = 18;
   localparam int ANG_W          = 18;
   localparam int GAIN_INV_Q14   = 9949;
   localparam int GAIN_W         = 15;

   typedef struct packed {
      logic [FACE_W-1:0] face;
      logic [PIX_W-1:0]  col;
      logic [PIX_W-1:0]  row;
   } req_type;

   typedef struct packed {
      logic [COORD_W-1:0] u_left;
      logic [COORD_W-1:0] v_top;
      logic [COORD_W-1:0] u_right;
      logic [COORD_W-1:0] v_bottom;
      logic [COORD_W-1:0] weight_s;
      logic [COORD_W-1:0] weight_t;
      logic [COORD_W-1:0] dest_x;
      logic [COORD_W-1:0] dest_y;
   } rsp_type;

   // Arctangent of 2^-k in Q14 half-turns.
   function automatic logic signed [ANG_W-1:0] atan_q14(input int k);
      logic signed [ANG_W-1:0] a;
      case (k)
         0:       a = 18'sd4096;
         1:       a = 18'sd2418;
         2:       a = 18'sd1278;
         3:       a = 18'sd649;
         4:       a = 18'sd326;
         5:       a = 18'sd163;
         6:       a = 18'sd81;
         7:       a = 18'sd41;
         8:       a = 18'sd20;
         9:       a = 18'sd10;
         10:      a = 18'sd5;
         11:      a = 18'sd3;
         12:      a = 18'sd1;
         13:      a = 18'sd1;
         default: a = 18'sd0;
      endcase
      return a;
   endfunction

   // Face offsets in the horizontal cross, in face edge lengths.
   function automatic logic [1:0] cross_ox(input logic [FACE_W-1:0] face);
      logic [1:0] o;
      case (face)
         3'd1:    o = 2'd1;
         3'd2:    o = 2'd2;
         3'd3:    o = 2'd3;
         3'd4:    o = 2'd1;
         3'd5:    o = 2'd1;
         default: o = 2'd0;
      endcase
      return o;
   endfunction

   function automatic logic [1:0] cross_oy(input logic [FACE_W-1:0] face);
      logic [1:0] o;
      case (face)
         3'd0:    o = 2'd1;
         3'd1:    o = 2'd1;
         3'd2:    o = 2'd1;
         3'd3:    o = 2'd1;
         3'd5:    o = 2'd2;
         default: o = 2'd0;
      endcase
      return o;
   endfunction

endpackage

>>> hw/rtl/ctsc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_div
// Pipelined restoring divider: (num << 15) / fs, saturated at three in Q14.
// Two quotient bits are resolved in each register stage.
// ----------------------------------------------------------------------------
module ctsc_div #(
   parameter int FS_W  = 12,
   parameter int TAG_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [ctsc_pkg::PIX_W-1:0]  in_num,
   input  logic [FS_W-1:0]             fs,
   input  logic [TAG_W-1:0]            in_tag,
   output logic                        out_valid,
   output logic [ctsc_pkg::QUO_W-1:0]  out_quo,
   output logic [TAG_W-1:0]            out_tag
);

   localparam int QW    = ctsc_pkg::QUO_W;
   localparam int BPS   = ctsc_pkg::DIV_BITS_PER_STAGE;
   localparam int NST   = QW / BPS;
   localparam int RW    = FS_W + 1;
   localparam int CMP_W = (FS_W + 2 > ctsc_pkg::PIX_W + 1) ? FS_W + 2 : ctsc_pkg::PIX_W + 1;

   logic           vld_ff [NST];
   logic           sat_ff [NST];
   logic [RW-1:0]  rem_ff [NST];
   logic [QW-1:0]  quo_ff [NST];
   logic [TAG_W-1:0] tag_ff [NST];

   // The ratio num/fs reaches 3/2 exactly when 2*num >= 3*fs.
   logic [CMP_W-1:0] num2;
   logic [CMP_W-1:0] fs3;
   logic             in_sat;
   logic [RW-1:0]    in_rem;

   always_comb begin
      num2   = CMP_W'({in_num, 1'b0});
      fs3    = CMP_W'({fs, 1'b0}) + CMP_W'(fs);
      in_sat = (num2 >= fs3);
      in_rem = RW'(in_num >> 1);
   end

   for (genvar s = 0; s < NST; s++) begin : g_st
      logic             vld_src;
      logic             sat_src;
      logic [RW-1:0]    rem_src;
      logic [QW-1:0]    quo_src;
      logic [TAG_W-1:0] tag_src;
      logic [RW-1:0]    rem_nx;
      logic [QW-1:0]    quo_nx;
      logic [RW:0]      trial;

      if (s == 0) begin : g_first
         always_comb begin
            vld_src = in_valid;
            sat_src = in_sat;
            rem_src = in_rem;
            quo_src = '0;
            tag_src = in_tag;
         end
      end else begin : g_next
         always_comb begin
            vld_src = vld_ff[s-1];
            sat_src = sat_ff[s-1];
            rem_src = rem_ff[s-1];
            quo_src = quo_ff[s-1];
            tag_src = tag_ff[s-1];
         end
      end

      always_comb begin
         rem_nx = rem_src;
         quo_nx = quo_src;
         trial  = '0;
         for (int b = 0; b < BPS; b++) begin
            // Only the very first step brings in a dividend bit, the LSB of num.
            trial = {rem_nx, (s == 0 && b == 0) ? in_num[0] : 1'b0};
            if (trial >= (RW+1)'(fs)) begin
               rem_nx = RW'(trial - (RW+1)'(fs));
               quo_nx = {quo_nx[QW-2:0], 1'b1};
            end else begin
               rem_nx = RW'(trial);
               quo_nx = {quo_nx[QW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (en) begin
            vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sat_ff[s] <= sat_src;
            rem_ff[s] <= rem_nx;
            quo_ff[s] <= quo_nx;
            tag_ff[s] <= tag_src;
         end
      end
   end

   assign out_valid = vld_ff[NST-1];
   assign out_quo   = sat_ff[NST-1] ? QW'(ctsc_pkg::QUO_SAT) : quo_ff[NST-1];
   assign out_tag   = tag_ff[NST-1];

endmodule

>>> hw/rtl/ctsc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_cordic
// Pipelined CORDIC vectoring unit: angle of (x, y) in Q14 half-turns and the
// gain-corrected magnitude. A zero vector gives zero angle and magnitude.
// ----------------------------------------------------------------------------
module ctsc_cordic #(
   parameter int TAG_W = 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic signed [ctsc_pkg::CRD_IN_W-1:0]   in_x,
   input  logic signed [ctsc_pkg::CRD_IN_W-1:0]   in_y,
   input  logic [TAG_W-1:0]                       in_tag,
   output logic                                   out_valid,
   output logic signed [ctsc_pkg::ANG_W-1:0]      out_ang,
   output logic signed [ctsc_pkg::CRD_IN_W-1:0]   out_mag,
   output logic [TAG_W-1:0]                       out_tag
);

   localparam int W   = ctsc_pkg::CRD_W;
   localparam int AW  = ctsc_pkg::ANG_W;
   localparam int PS  = ctsc_pkg::CRD_PER_STAGE;
   localparam int NIT = ctsc_pkg::CRD_STEPS / PS;
   localparam int PW  = W + ctsc_pkg::GAIN_W;

   // Pre-rotation stage.
   logic                  pre_vld_ff;
   logic                  pre_zero_ff;
   logic signed [W-1:0]   pre_x_ff;
   logic signed [W-1:0]   pre_y_ff;
   logic signed [AW-1:0]  pre_z_ff;
   logic [TAG_W-1:0]      pre_tag_ff;

   logic signed [W-1:0]   pre_x_in;
   logic signed [W-1:0]   pre_y_in;
   logic signed [AW-1:0]  pre_z_in;
   logic                  pre_zero_in;

   always_comb begin
      pre_zero_in = (in_x == '0) && (in_y == '0);
      pre_x_in    = W'(in_x);
      pre_y_in    = W'(in_y);
      pre_z_in    = '0;
      if (in_x < 0) begin
         // Fold the left half-plane over by a half-turn.
         pre_z_in = (in_y >= 0) ? AW'(ctsc_pkg::Q14_ONE) : -AW'(ctsc_pkg::Q14_ONE);
         pre_x_in = -W'(in_x);
         pre_y_in = -W'(in_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_vld_ff <= 1'b0;
      end else if (en) begin
         pre_vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_zero_ff <= pre_zero_in;
         pre_x_ff    <= pre_x_in;
         pre_y_ff    <= pre_y_in;
         pre_z_ff    <= pre_z_in;
         pre_tag_ff  <= in_tag;
      end
   end

   // Micro-rotation stages.
   logic                  it_vld_ff  [NIT];
   logic                  it_zero_ff [NIT];
   logic signed [W-1:0]   it_x_ff    [NIT];
   logic signed [W-1:0]   it_y_ff    [NIT];
   logic signed [AW-1:0]  it_z_ff    [NIT];
   logic [TAG_W-1:0]      it_tag_ff  [NIT];

   for (genvar s = 0; s < NIT; s++) begin : g_it
      logic                  vld_src;
      logic                  zero_src;
      logic signed [W-1:0]   x_src;
      logic signed [W-1:0]   y_src;
      logic signed [AW-1:0]  z_src;
      logic [TAG_W-1:0]      tag_src;
      logic signed [W-1:0]   x_nx;
      logic signed [W-1:0]   y_nx;
      logic signed [AW-1:0]  z_nx;
      logic signed [W-1:0]   xs;
      logic signed [W-1:0]   ys;

      if (s == 0) begin : g_first
         always_comb begin
            vld_src  = pre_vld_ff;
            zero_src = pre_zero_ff;
            x_src    = pre_x_ff;
            y_src    = pre_y_ff;
            z_src    = pre_z_ff;
            tag_src  = pre_tag_ff;
         end
      end else begin : g_next
         always_comb begin
            vld_src  = it_vld_ff[s-1];
            zero_src = it_zero_ff[s-1];
            x_src    = it_x_ff[s-1];
            y_src    = it_y_ff[s-1];
            z_src    = it_z_ff[s-1];
            tag_src  = it_tag_ff[s-1];
         end
      end

      always_comb begin
         x_nx = x_src;
         y_nx = y_src;
         z_nx = z_src;
         xs   = '0;
         ys   = '0;
         for (int b = 0; b < PS; b++) begin
            xs = x_nx >>> (s * PS + b);
            ys = y_nx >>> (s * PS + b);
            if (!y_nx[W-1]) begin
               x_nx = x_nx + ys;
               y_nx = y_nx - xs;
               z_nx = z_nx + ctsc_pkg::atan_q14(s * PS + b);
            end else begin
               x_nx = x_nx - ys;
               y_nx = y_nx + xs;
               z_nx = z_nx - ctsc_pkg::atan_q14(s * PS + b);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            it_vld_ff[s] <= 1'b0;
         end else if (en) begin
            it_vld_ff[s] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            it_zero_ff[s] <= zero_src;
            it_x_ff[s]    <= x_nx;
            it_y_ff[s]    <= y_nx;
            it_z_ff[s]    <= z_nx;
            it_tag_ff[s]  <= tag_src;
         end
      end
   end

   // Gain correction with round-half-up.
   logic                          out_vld_ff;
   logic signed [AW-1:0]          out_ang_ff;
   logic signed [ctsc_pkg::CRD_IN_W-1:0] out_mag_ff;
   logic [TAG_W-1:0]              out_tag_ff;
   logic signed [PW-1:0]          mag_prod;
   logic signed [PW-1:0]          mag_shift;

   always_comb begin
      mag_prod  = PW'(it_x_ff[NIT-1]) * PW'(ctsc_pkg::GAIN_INV_Q14)
                + PW'(ctsc_pkg::Q14_HALF);
      mag_shift = mag_prod >>> ctsc_pkg::Q14_FRAC;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= it_vld_ff[NIT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ang_ff <= it_zero_ff[NIT-1] ? '0 : it_z_ff[NIT-1];
         out_mag_ff <= it_zero_ff[NIT-1] ? '0 : ctsc_pkg::CRD_IN_W'(mag_shift);
         out_tag_ff <= it_tag_ff[NIT-1];
      end
   end

   assign out_valid = out_vld_ff;
   assign out_ang   = out_ang_ff;
   assign out_mag   = out_mag_ff;
   assign out_tag   = out_tag_ff;

endmodule

>>> hw/rtl/ctsc_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctsc_split
// Splits one Q14 source position into clamped neighbor coordinates and a
// bilinear weight, registered.
// ----------------------------------------------------------------------------
module ctsc_split #(
   parameter int POS_W     = 33,
   parameter int FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [POS_W-1:0]             in_pos,
   input  logic [ctsc_pkg::COORD_W-1:0]        lim,
   output logic [ctsc_pkg::COORD_W-1:0]        out_lo,
   output logic [ctsc_pkg::COORD_W-1:0]        out_hi,
   output logic [ctsc_pkg::COORD_W-1:0]        out_w
);

   localparam int CW  = ctsc_pkg::COORD_W;
   localparam int QF  = ctsc_pkg::Q14_FRAC;
   localparam int FW  = POS_W - QF;
   localparam int FRW = QF + 1;
   localparam int WW  = FRW + FRAC_BITS;

   logic [CW-1:0]        lo_ff;
   logic [CW-1:0]        hi_ff;
   logic [CW-1:0]        w_ff;

   logic                 neg;
   logic                 over;
   logic [FW-1:0]        flr;
   logic [CW-1:0]        lo_in;
   logic [CW:0]          lo_p1;
   logic [CW-1:0]        hi_in;
   logic [FRW-1:0]       fr;
   logic [WW-1:0]        wsh;

   always_comb begin
      neg   = in_pos[POS_W-1];
      flr   = FW'(in_pos >>> QF);
      over  = !neg && (flr > FW'(lim));
      if (neg) begin
         lo_in = '0;
         fr    = '0;
      end else if (over) begin
         lo_in = lim;
         fr    = FRW'(ctsc_pkg::Q14_ONE);
      end else begin
         lo_in = CW'(flr);
         fr    = {1'b0, in_pos[QF-1:0]};
      end
      lo_p1 = {1'b0, lo_in} + (CW+1)'(1);
      hi_in = (lo_p1 > {1'b0, lim}) ? lim : CW'(lo_p1);
      wsh   = {fr, {FRAC_BITS{1'b0}}} >> QF;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         w_ff  <= wsh[CW-1:0];
      end
   end

   assign out_lo = lo_ff;
   assign out_hi = hi_ff;
   assign out_w  = w_ff;

endmodule

>>> hw/rtl/cube_to_equirect_sample_coords_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube_to_equirect_sample_coords_unit
// Maps a cube face pixel to equirectangular bilinear sample coordinates and
// to its place in the horizontal-cross image.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while req_stall is low and returns
// one result item for each, in order. The pipeline holds 8 divider stages
// that form the face-relative coordinates (two quotient bits per stage), one
// stage that builds the direction vector, two 9-stage CORDIC vectoring units
// (azimuth, then elevation over the horizontal magnitude), one stage for the
// source position multiply, one split stage and the output register. A skid
// register behind the output lets the pipeline hand over one more item while
// a result waits; when both hold an item the whole pipeline, and the input,
// stall. The configuration registers must only be written while no item is in
// flight; face_size of zero acts as one and values above FACE_MAX saturate.
module cube_to_equirect_sample_coords_unit #(
   parameter int FACE_MAX  = 2048,
   parameter int FRAC_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  ctsc_pkg::req_type                   req_data,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ctsc_pkg::rsp_type                   rsp_data,

   input  logic                                csr_we,
   input  logic [ctsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ctsc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int FS_W  = $clog2(FACE_MAX + 1);
   localparam int CW    = ctsc_pkg::COORD_W;
   localparam int QW    = ctsc_pkg::QUO_W;
   localparam int VW    = ctsc_pkg::COORD_Q_W;
   localparam int AW    = ctsc_pkg::ANG_W;
   localparam int IW    = ctsc_pkg::CRD_IN_W;
   localparam int POS_W = AW + 1 + FS_W + 2;
   localparam int XW    = ((FS_W + 2 > ctsc_pkg::PIX_W) ? FS_W + 2 : ctsc_pkg::PIX_W) + 1;

   typedef struct packed {
      logic [ctsc_pkg::FACE_W-1:0] face;
      logic [CW-1:0]               dest_x;
      logic [CW-1:0]               dest_y;
   } div_tag_type;

   typedef struct packed {
      logic [CW-1:0] dest_x;
      logic [CW-1:0] dest_y;
   } dest_type;

   typedef struct packed {
      logic signed [VW-1:0] vz;
      dest_type             dest;
   } az_tag_type;

   typedef struct packed {
      logic signed [AW-1:0] theta;
      dest_type             dest;
   } el_tag_type;

   // ------------------------------------------------------------------------
   // Configuration registers.
   // ------------------------------------------------------------------------
   logic [11:0]   face_size_ff;
   logic [CW-1:0] src_x_max_ff;
   logic [CW-1:0] src_y_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         face_size_ff <= 12'd256;
         src_x_max_ff <= 13'd1023;
         src_y_max_ff <= 13'd511;
      end else if (csr_we) begin
         if (csr_index == ctsc_pkg::CSR_FACE_SIZE) begin
            face_size_ff <= csr_wdata[11:0];
         end
         if (csr_index == ctsc_pkg::CSR_SRC_X_MAX) begin
            src_x_max_ff <= csr_wdata;
         end
         if (csr_index == ctsc_pkg::CSR_SRC_Y_MAX) begin
            src_y_max_ff <= csr_wdata;
         end
      end
   end

   // Effective edge length. The user must let it change only while the unit is idle; the block does not enforce it.
   logic [FS_W-1:0] fs_eff;

   always_comb begin
      if (face_size_ff == '0) begin
         fs_eff = FS_W'(1);
      end else if ({1'b0, face_size_ff} > 13'(FACE_MAX)) begin
         fs_eff = FS_W'(FACE_MAX);
      end else begin
         fs_eff = FS_W'(face_size_ff);
      end
   end

   // ------------------------------------------------------------------------
   // Flow control: the pipeline advances as long as the skid register is free.
   // ------------------------------------------------------------------------
   logic    out_valid_ff;
   logic    skid_valid_ff;
   logic    en;
   logic    in_take;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign in_take   = req_valid && !req_stall;

   // ------------------------------------------------------------------------
   // Cross position, formed at the input and carried along.
   // ------------------------------------------------------------------------
   div_tag_type     in_tag;
   logic [1:0]      ox;
   logic [1:0]      oy;
   logic [XW-1:0]   dx_sum;
   logic [XW-1:0]   dy_sum;

   always_comb begin
      ox     = ctsc_pkg::cross_ox(req_data.face);
      oy     = ctsc_pkg::cross_oy(req_data.face);
      dx_sum = (ox[1] ? XW'({fs_eff, 1'b0}) : '0) + (ox[0] ? XW'(fs_eff) : '0)
             + XW'(req_data.col);
      dy_sum = (oy[1] ? XW'({fs_eff, 1'b0}) : '0) + (oy[0] ? XW'(fs_eff) : '0)
             + XW'(req_data.row);
      in_tag.face = req_data.face;
      if (req_data.face > 3'd5) begin
         in_tag.dest_x = '0;
         in_tag.dest_y = '0;
      end else begin
         in_tag.dest_x = CW'(dx_sum);
         in_tag.dest_y = CW'(dy_sum);
      end
   end

   // ------------------------------------------------------------------------
   // Face-relative coordinates qi = (col << 15) / fs and qj likewise.
   // ------------------------------------------------------------------------
   logic            div_valid;
   logic            div_valid_j;
   logic [QW-1:0]   qi;
   logic [QW-1:0]   qj;
   div_tag_type     div_tag;
   div_tag_type     div_tag_j;

   ctsc_div #(
      .FS_W  (FS_W),
      .TAG_W ($bits(div_tag_type))
   ) u_div_col (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_take),
      .in_num    (req_data.col),
      .fs        (fs_eff),
      .in_tag    (in_tag),
      .out_valid (div_valid),
      .out_quo   (qi),
      .out_tag   (div_tag)
   );

   ctsc_div #(
      .FS_W  (FS_W),
      .TAG_W ($bits(div_tag_type))
   ) u_div_row (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (in_take),
      .in_num    (req_data.row),
      .fs        (fs_eff),
      .in_tag    (in_tag),
      .out_valid (div_valid_j),
      .out_quo   (qj),
      .out_tag   (div_tag_j)
   );

   // ------------------------------------------------------------------------
   // Direction vector from the six face rules.
   // ------------------------------------------------------------------------
   function automatic logic signed [VW-1:0] sat_q14(input logic signed [VW:0] v);
      logic signed [VW-1:0] r;
      if (v > (VW+1)'(signed'(32767))) begin
         r = 16'sh7fff;
      end else if (v < -(VW+1)'(signed'(32768))) begin
         r = 16'sh8000;
      end else begin
         r = v[VW-1:0];
      end
      return r;
   endfunction

   logic signed [VW-1:0] pim;
   logic signed [VW-1:0] mpi;
   logic signed [VW-1:0] pjm;
   logic signed [VW-1:0] mpj;
   logic signed [VW-1:0] vx_in;
   logic signed [VW-1:0] vy_in;
   logic signed [VW-1:0] vz_in;

   logic                 vec_valid_ff;
   logic signed [VW-1:0] vx_ff;
   logic signed [VW-1:0] vy_ff;
   az_tag_type           vec_tag_ff;

   always_comb begin
      pim = sat_q14($signed({1'b0, qi}) - (VW+1)'(ctsc_pkg::Q14_ONE));
      mpi = sat_q14((VW+1)'(ctsc_pkg::Q14_ONE) - $signed({1'b0, qi}));
      pjm = sat_q14($signed({1'b0, qj}) - (VW+1)'(ctsc_pkg::Q14_ONE));
      mpj = sat_q14((VW+1)'(ctsc_pkg::Q14_ONE) - $signed({1'b0, qj}));
      case (div_tag.face)
         3'd0: begin
            vx_in = pim;
            vy_in = -VW'(ctsc_pkg::Q14_ONE);
            vz_in = mpj;
         end
         3'd1: begin
            vx_in = VW'(ctsc_pkg::Q14_ONE);
            vy_in = pim;
            vz_in = mpj;
         end
         3'd2: begin
            vx_in = mpi;
            vy_in = VW'(ctsc_pkg::Q14_ONE);
            vz_in = mpj;
         end
         3'd3: begin
            vx_in = -VW'(ctsc_pkg::Q14_ONE);
            vy_in = mpi;
            vz_in = mpj;
         end
         3'd4: begin
            vx_in = pjm;
            vy_in = pim;
            vz_in = VW'(ctsc_pkg::Q14_ONE);
         end
         3'd5: begin
            vx_in = mpj;
            vy_in = pim;
            vz_in = -VW'(ctsc_pkg::Q14_ONE);
         end
         default: begin
            // Faces six and seven have no direction.
            vx_in = '0;
            vy_in = '0;
            vz_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_valid_ff <= 1'b0;
      end else if (en) begin
         vec_valid_ff <= div_valid && div_valid_j;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vx_ff                    <= vx_in;
         vy_ff                    <= vy_in;
         vec_tag_ff.vz            <= vz_in;
         vec_tag_ff.dest.dest_x   <= div_tag_j.dest_x;
         vec_tag_ff.dest.dest_y   <= div_tag_j.dest_y;
      end
   end

   // ------------------------------------------------------------------------
   // Azimuth theta = atan2(vy, vx) and horizontal magnitude.
   // ------------------------------------------------------------------------
   logic                 az_valid;
   logic signed [AW-1:0] theta;
   logic signed [IW-1:0] rxy;
   az_tag_type           az_tag;
   el_tag_type           el_in_tag;

   ctsc_cordic #(
      .TAG_W ($bits(az_tag_type))
   ) u_cordic_az (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vec_valid_ff),
      .in_x      (IW'(vx_ff)),
      .in_y      (IW'(vy_ff)),
      .in_tag    (vec_tag_ff),
      .out_valid (az_valid),
      .out_ang   (theta),
      .out_mag   (rxy),
      .out_tag   (az_tag)
   );

   // ------------------------------------------------------------------------
   // Elevation phi = atan2(vz, rxy); theta travels alongside.
   // ------------------------------------------------------------------------
   logic                 el_valid;
   logic signed [AW-1:0] phi;
   logic signed [IW-1:0] el_mag;
   el_tag_type           el_tag;

   assign el_in_tag.theta = theta;
   assign el_in_tag.dest  = az_tag.dest;

   ctsc_cordic #(
      .TAG_W ($bits(el_tag_type))
   ) u_cordic_el (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (az_valid),
      .in_x      (rxy),
      .in_y      (IW'(az_tag.vz)),
      .in_tag    (el_in_tag),
      .out_valid (el_valid),
      .out_ang   (phi),
      .out_mag   (el_mag),
      .out_tag   (el_tag)
   );

   // ------------------------------------------------------------------------
   // Source position: U = 2*fs*(theta + 1), V = 2*fs*(1/2 - phi), Q14.
   // ------------------------------------------------------------------------
   logic signed [FS_W+1:0]  fs2;
   logic signed [AW:0]      u_ang;
   logic signed [AW:0]      v_ang;
   logic                    pos_valid_ff;
   logic signed [POS_W-1:0] upos_ff;
   logic signed [POS_W-1:0] vpos_ff;
   dest_type                pos_dest_ff;

   always_comb begin
      fs2   = $signed({1'b0, fs_eff, 1'b0});
      u_ang = (AW+1)'(el_tag.theta) + (AW+1)'(ctsc_pkg::Q14_ONE);
      v_ang = (AW+1)'(ctsc_pkg::Q14_HALF) - (AW+1)'(phi);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_valid_ff <= 1'b0;
      end else if (en) begin
         pos_valid_ff <= el_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         upos_ff     <= POS_W'(fs2) * POS_W'(u_ang);
         vpos_ff     <= POS_W'(fs2) * POS_W'(v_ang);
         pos_dest_ff <= el_tag.dest;
      end
   end

   // ------------------------------------------------------------------------
   // Neighbors and weights.
   // ------------------------------------------------------------------------
   logic          spl_valid_ff;
   dest_type      spl_dest_ff;
   logic [CW-1:0] u_lo;
   logic [CW-1:0] u_hi;
   logic [CW-1:0] w_s;
   logic [CW-1:0] v_lo;
   logic [CW-1:0] v_hi;
   logic [CW-1:0] w_t;

   ctsc_split #(
      .POS_W     (POS_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_split_u (
      .clock  (clock),
      .en     (en),
      .in_pos (upos_ff),
      .lim    (src_x_max_ff),
      .out_lo (u_lo),
      .out_hi (u_hi),
      .out_w  (w_s)
   );

   ctsc_split #(
      .POS_W     (POS_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_split_v (
      .clock  (clock),
      .en     (en),
      .in_pos (vpos_ff),
      .lim    (src_y_max_ff),
      .out_lo (v_lo),
      .out_hi (v_hi),
      .out_w  (w_t)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         spl_valid_ff <= 1'b0;
      end else if (en) begin
         spl_valid_ff <= pos_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         spl_dest_ff <= pos_dest_ff;
      end
   end

   ctsc_pkg::rsp_type pipe_data;

   always_comb begin
      pipe_data.u_left   = u_lo;
      pipe_data.v_top    = v_lo;
      pipe_data.u_right  = u_hi;
      pipe_data.v_bottom = v_hi;
      pipe_data.weight_s = w_s;
      pipe_data.weight_t = w_t;
      pipe_data.dest_x   = spl_dest_ff.dest_x;
      pipe_data.dest_y   = spl_dest_ff.dest_y;
   end

   // ------------------------------------------------------------------------
   // Output register and skid register.
   // ------------------------------------------------------------------------
   ctsc_pkg::rsp_type out_data_ff;
   ctsc_pkg::rsp_type skid_data_ff;
   logic              out_take;

   assign out_take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (spl_valid_ff) begin
         if (out_valid_ff && !out_take) begin
            skid_valid_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (spl_valid_ff) begin
         if (out_valid_ff && !out_take) begin
            skid_data_ff <= pipe_data;
         end else begin
            out_data_ff <= pipe_data;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------
`ifndef ASSERT_OFF
   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds an item while the output is empty");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      (spl_valid_ff && !skid_valid_ff && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("item leaving the pipeline was not caught by the skid register");

   a_u_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.u_left <= src_x_max_ff && rsp_data.u_right <= src_x_max_ff))
      else $error("horizontal neighbor beyond the source width");

   a_v_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.v_top <= src_y_max_ff && rsp_data.v_bottom <= src_y_max_ff))
      else $error("vertical neighbor beyond the source height");
`endif

endmodule
